[design/cda_pkg.sv]
// ----------------------------------------------------------------------------
// cda_pkg
// Types, constants and calendar helpers for the date advance block.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int MAX_YEAR       = 9999;
  localparam int YEAR_FIELD_MAX = 16383;
  localparam int YEAR_W         = 14;
  localparam int MONTH_W        = 4;
  localparam int DAY_W          = 5;

  // Largest year the result can carry.
  localparam logic [YEAR_W-1:0] YEAR_LIMIT =
    YEAR_W'((MAX_YEAR < YEAR_FIELD_MAX) ? MAX_YEAR : YEAR_FIELD_MAX);

  // Multiplicative inverse of 25 modulo 2**14 and the divisibility bound.
  localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
  localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
  localparam logic [DAY_W-1:0] LEN_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;

  localparam logic [1:0] ACT_YEAR  = 2'd0;
  localparam logic [1:0] ACT_MONTH = 2'd1;
  localparam logic [1:0] ACT_DAY   = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_WRAP    = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [YEAR_W-1:0]  in_year;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
  } in_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [1:0]         status;
  } out_item_t;

  // Leap test by the 4/100/400 rule; divisibility by 25 via the inverse.
  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] p;
    logic              div25;
    p     = y * INV25;
    div25 = (p <= DIV25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:2] == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
      MONTH_FEB: len = leap ? LEN_LEAP : LEN_FEB;
      default:   len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

[design/calendar_date_advance.sv]
// ----------------------------------------------------------------------------
// calendar_date_advance
// Advances a Gregorian date by one year, one month or one day.
// ----------------------------------------------------------------------------
// One transfer in, one result out. busy is tied low: a new
// date is taken on every cycle that start is high, and each result appears
// on out_data for exactly one cycle with out_strobe high. The receiver cannot
// stall the block, so it must capture every strobed result. Throughput is one
// date per clock; latency is set by the input register and the result
// register, with the whole date arithmetic in one short pass between them.
// Day overflow carries into the next month (Jan 31 plus one month gives
// Mar 3 in a common year), December carries into the year, and a year past
// the limit wraps to zero with status STATUS_WRAP. An invalid date passes
// through unchanged with status STATUS_INVALID.
// ----------------------------------------------------------------------------
module calendar_date_advance (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cda_pkg::in_item_t  in_data,
  output logic               out_strobe,
  output cda_pkg::out_item_t out_data
);
  import cda_pkg::*;

  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;

  // Fields of the held date.
  logic [YEAR_W-1:0]  y;
  logic [MONTH_W-1:0] m;
  logic [DAY_W-1:0]   d;

  // Year and month one step on, with wrap flag.
  logic [YEAR_W-1:0]  y_inc;
  logic               y_wrap;
  logic [MONTH_W-1:0] m_inc;
  logic               leap0;
  logic               leap1;
  logic               date_ok;

  // After the chosen step.
  logic [YEAR_W-1:0]  y1;
  logic [MONTH_W-1:0] m1;
  logic [DAY_W:0]     d1;
  logic               lp1;
  logic               w1;
  logic [DAY_W-1:0]   len1;
  logic [DAY_W:0]     d_excess;

  // The block never holds off a transfer.
  assign busy = 1'b0;

  assign y = in_data_r.in_year;
  assign m = in_data_r.in_month;
  assign d = in_data_r.in_day;

  assign y_wrap = (y >= YEAR_LIMIT);
  assign y_inc  = y_wrap ? '0 : y + 1'b1;
  assign m_inc  = (m == MONTH_DEC) ? MONTH_JAN : m + 1'b1;

  // Leap status of this year and of the next one, in parallel.
  assign leap0 = leap_year(y);
  assign leap1 = leap_year(y_inc);

  assign date_ok = (m >= MONTH_JAN) && (m <= MONTH_DEC) && (d != '0) &&
                   (d <= month_len(leap0, m)) && (y <= YEAR_LIMIT);

  always_comb begin
    y1  = y;
    m1  = m;
    d1  = {1'b0, d};
    lp1 = leap0;
    w1  = 1'b0;
    case (in_data_r.action)
      ACT_YEAR: begin
        y1  = y_inc;
        lp1 = leap1;
        w1  = y_wrap;
      end
      ACT_MONTH: begin
        m1 = m_inc;
        if (m == MONTH_DEC) begin
          y1  = y_inc;
          lp1 = leap1;
          w1  = y_wrap;
        end
      end
      ACT_DAY: begin
        d1 = {1'b0, d} + 1'b1;
      end
      default: begin
        // ACT_NONE: keep the date as it is.
      end
    endcase
  end

  assign len1     = month_len(lp1, m1);
  assign d_excess = d1 - {1'b0, len1};

  // Fold day overflow into the next month, and December into the year; pass an invalid date through.
  always_comb begin
    out_data_nxt.out_year  = y1;
    out_data_nxt.out_month = m1;
    out_data_nxt.out_day   = d1[DAY_W-1:0];
    out_data_nxt.status    = w1 ? STATUS_WRAP : STATUS_OK;
    if (!date_ok) begin
      out_data_nxt.out_year  = y;
      out_data_nxt.out_month = m;
      out_data_nxt.out_day   = d;
      out_data_nxt.status    = STATUS_INVALID;
    end else if (d1 > {1'b0, len1}) begin
      out_data_nxt.out_day = d_excess[DAY_W-1:0];
      if (m1 == MONTH_DEC) begin
        out_data_nxt.out_month = MONTH_JAN;
        if (y1 >= YEAR_LIMIT) begin
          out_data_nxt.out_year = '0;
          out_data_nxt.status   = STATUS_WRAP;
        end else begin
          out_data_nxt.out_year = y1 + 1'b1;
        end
      end else begin
        out_data_nxt.out_month = m1 + 1'b1;
      end
    end
  end

  // Control flags: clear on reset, advance every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  // Payload: capture on transfer, hold the result for its strobe cycle.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_data_r <= in_data;
    end
    if (in_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_data   = out_data_r;

endmodule
